@@ sv/mrfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrfr_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] FUNC_ARM  = 2'd0;
   localparam logic [1:0] FUNC_BYTE = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // Response status codes
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RECV    = 3'd1;
   localparam logic [2:0] ST_GOOD    = 3'd2;
   localparam logic [2:0] ST_CRCERR  = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_DISCARD = 3'd5;

   // Register indexes
   localparam logic CSR_SLAVE_ADDR = 1'b0;
   localparam logic CSR_TIMEOUT    = 1'b1;

   // Register reset values
   localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
   localparam logic [15:0] TIMEOUT_RST    = 16'd200;

   // Modbus function codes handled
   localparam logic [7:0] MB_READ_HOLD  = 8'h03;
   localparam logic [7:0] MB_WRITE_MULT = 8'h10;

   // Frame constants
   localparam logic [8:0]  LEN_WRITE_MULT = 9'd8;
   localparam logic [8:0]  LEN_OVERHEAD   = 9'd5;
   localparam logic [8:0]  LEN_HUNT       = 9'd255;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   // Bus widths
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Receive phase, one-hot
   typedef enum logic [3:0] {
      PH_ADDR  = 4'b0001,
      PH_FUNC  = 4'b0010,
      PH_COUNT = 4'b0100,
      PH_BODY  = 4'b1000
   } phase_type;

   // CRC-16 over one byte, reflected polynomial, unrolled bit by bit
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/modbus_response_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU response receiver.
// Request channel (req_*): one item per event. req_tuser carries the kind
// (arm, received byte, timer tick), req_tdata the received byte.
// Response channel (rsp_*): exactly one item per request item, in order.
// rsp_tuser carries status and the byte-stored flag, rsp_tdata the byte
// position, byte value and, on a good frame, the frame length.
// Register port (csr_*): slave address and timeout in ticks; write only
// while no item is in flight.
// An accepted item sits in the input register, and its response is loaded
// into the output register when that register is empty or being drained.
// Throughput: one item per cycle while the output is not stalled; the CRC
// of a byte is an unrolled 8-step network between the input register and
// the output register. Reset clears both pipeline registers, disarms the
// receiver and restores register defaults (address 1, 200 ticks). When
// rsp_tready is low the output register holds its item; the input register
// still takes one more item, then req_tready drops until the output drains.
module modbus_response_frame_receiver_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   // Request channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [mrfr_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [7:0] rx_byte
   input  wire  [mrfr_pkg::REQ_TUSER_W-1:0]    req_tuser,   // [1:0] func
   // Response channel
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mrfr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [8:0] byte_index,
                                                            // [16:9] byte_out,
                                                            // [25:17] frame_length
   output logic [mrfr_pkg::RSP_TUSER_W-1:0]    rsp_tuser,   // [2:0] status, [3] byte_valid
   // Register write port
   input  wire                                 csr_we,
   input  wire                                 csr_index,
   input  wire  [mrfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mrfr_pkg::*;

   // Registers
   logic        in_valid_ff;
   logic [1:0]  in_func_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_TUSER_W-1:0] out_user_ff, out_user_in;

   logic [7:0]  slave_addr_ff;
   logic [15:0] timeout_ff;

   logic        armed_ff, armed_in;
   phase_type   phase_ff, phase_in;
   logic [8:0]  count_ff, count_in;
   logic [8:0]  exp_len_ff, exp_len_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] ticks_ff, ticks_in;

   // Handshake
   logic out_ready;
   logic fire;

   // Datapath helpers
   logic [15:0] crc_step;
   logic [8:0]  count_inc;
   logic [9:0]  count_plus2;
   logic [2:0]  status;
   logic        byte_valid;
   logic [8:0]  byte_index;
   logic [7:0]  byte_out;
   logic [8:0]  frame_len;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_ready;
   assign fire       = in_valid_ff && out_ready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   assign crc_step    = crc16_byte(crc_ff, in_byte_ff);
   assign count_inc   = count_ff + 9'd1;
   assign count_plus2 = {1'b0, count_ff} + 10'd2;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= SLAVE_ADDR_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDR: slave_addr_ff <= csr_wdata[7:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Receiver next state and response
   always_comb begin
      armed_in   = armed_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      exp_len_in = exp_len_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      ticks_in   = ticks_ff;
      status     = armed_ff ? ST_RECV : ST_IDLE;
      byte_valid = 1'b0;
      byte_index = 9'd0;
      byte_out   = 8'd0;
      frame_len  = 9'd0;

      case (in_func_ff)
         FUNC_ARM: begin
            armed_in   = 1'b1;
            phase_in   = PH_ADDR;
            count_in   = 9'd0;
            exp_len_in = LEN_HUNT;
            crc_in     = CRC_INIT;
            crc_low_in = 8'd0;
            ticks_in   = timeout_ff;
            status     = ST_RECV;
         end
         FUNC_TICK: begin
            if (armed_ff) begin
               if (ticks_ff <= 16'd1) begin
                  // timed out: drop everything
                  ticks_in   = 16'd0;
                  armed_in   = 1'b0;
                  phase_in   = PH_ADDR;
                  count_in   = 9'd0;
                  exp_len_in = LEN_HUNT;
                  crc_in     = CRC_INIT;
                  crc_low_in = 8'd0;
                  status     = ST_TIMEOUT;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end
         FUNC_BYTE: begin
            if (armed_ff) begin
               unique case (phase_ff)
                  PH_ADDR: begin
                     // hunt for our address, drop others silently
                     if (in_byte_ff == slave_addr_ff) begin
                        byte_valid = 1'b1;
                        byte_out   = in_byte_ff;
                        crc_in     = crc_step;
                        count_in   = 9'd1;
                        phase_in   = PH_FUNC;
                     end
                  end
                  PH_FUNC: begin
                     if (in_byte_ff == MB_READ_HOLD || in_byte_ff == MB_WRITE_MULT) begin
                        byte_valid = 1'b1;
                        byte_index = count_ff;
                        byte_out   = in_byte_ff;
                        crc_in     = crc_step;
                        count_in   = count_inc;
                        if (in_byte_ff == MB_READ_HOLD) begin
                           phase_in = PH_COUNT;
                        end else begin
                           exp_len_in = LEN_WRITE_MULT;
                           phase_in   = PH_BODY;
                        end
                     end else begin
                        // unsupported function: back to hunting
                        phase_in   = PH_ADDR;
                        count_in   = 9'd0;
                        exp_len_in = LEN_HUNT;
                        crc_in     = CRC_INIT;
                        crc_low_in = 8'd0;
                        status     = ST_DISCARD;
                     end
                  end
                  PH_COUNT: begin
                     byte_valid = 1'b1;
                     byte_index = count_ff;
                     byte_out   = in_byte_ff;
                     crc_in     = crc_step;
                     count_in   = count_inc;
                     exp_len_in = {1'b0, in_byte_ff} + LEN_OVERHEAD;
                     phase_in   = PH_BODY;
                  end
                  PH_BODY: begin
                     byte_valid = 1'b1;
                     byte_index = count_ff;
                     byte_out   = in_byte_ff;
                     count_in   = count_inc;
                     // CRC over payload, latch low CRC byte
                     if (count_plus2 < {1'b0, exp_len_ff}) begin
                        crc_in = crc_step;
                     end else if (count_plus2 == {1'b0, exp_len_ff}) begin
                        crc_low_in = in_byte_ff;
                     end
                     // last byte: check and close
                     if (count_inc >= exp_len_ff) begin
                        if ({in_byte_ff, crc_low_ff} == crc_ff) begin
                           status    = ST_GOOD;
                           frame_len = exp_len_ff;
                        end else begin
                           status = ST_CRCERR;
                        end
                        armed_in   = 1'b0;
                        phase_in   = PH_ADDR;
                        count_in   = 9'd0;
                        exp_len_in = LEN_HUNT;
                        crc_in     = CRC_INIT;
                        crc_low_in = 8'd0;
                     end
                  end
                  default: begin
                     phase_in   = PH_ADDR;
                     count_in   = 9'd0;
                     exp_len_in = LEN_HUNT;
                     crc_in     = CRC_INIT;
                     crc_low_in = 8'd0;
                  end
               endcase
            end
         end
         default: ;
      endcase

      out_user_in = {byte_valid, status};
      out_data_in = {{(RSP_TDATA_W - 26){1'b0}}, frame_len, byte_out, byte_index};
   end

   // Receiver state
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         phase_ff   <= PH_ADDR;
         count_ff   <= 9'd0;
         exp_len_ff <= LEN_HUNT;
         crc_ff     <= CRC_INIT;
         crc_low_ff <= 8'd0;
         ticks_ff   <= 16'd0;
      end else if (fire) begin
         armed_ff   <= armed_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         exp_len_ff <= exp_len_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         ticks_ff   <= ticks_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/mrfr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrfr_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire [mrfr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input wire [mrfr_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [mrfr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire [mrfr_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input wire                                csr_we,
   input wire                                csr_index,
   input wire [mrfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mrfr_pkg::*;

   // Stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response item changed while stalled");

   // Frame length only reported on a good frame
   a_len_good: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != ST_GOOD |-> rsp_tdata[25:17] == 9'd0)
      else $error("frame length without good frame");

   // No stored byte means zero position and value
   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[16:0] == 17'd0)
      else $error("byte fields set without stored byte");

   // A frame closes only on a stored byte
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == ST_GOOD || rsp_tuser[2:0] == ST_CRCERR)
      |-> rsp_tuser[3])
      else $error("frame end without a stored byte");

endmodule

bind modbus_response_frame_receiver_unit mrfr_checker u_mrfr_checker (.*);

`default_nettype wire
